### sv/ipv4c_pkg.sv
package ipv4c_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FLAGS_W = 10;
  localparam int unsigned PLEN_W  = 6;
  localparam int unsigned BYTES   = ADDR_W / 8;

  // class flag bit positions
  localparam int unsigned FLG_UNSPEC   = 0;
  localparam int unsigned FLG_LOOPBACK = 1;
  localparam int unsigned FLG_MCAST    = 2;
  localparam int unsigned FLG_LINKLOC  = 3;
  localparam int unsigned FLG_PRIVATE  = 4;
  localparam int unsigned FLG_CGNAT    = 5;
  localparam int unsigned FLG_DOC      = 6;
  localparam int unsigned FLG_BENCH    = 7;
  localparam int unsigned FLG_RSVD     = 8;
  localparam int unsigned FLG_LBCAST   = 9;

  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  localparam logic [ADDR_W-1:0] MSK_8  = 32'hFF00_0000;
  localparam logic [ADDR_W-1:0] MSK_4  = 32'hF000_0000;
  localparam logic [ADDR_W-1:0] MSK_10 = 32'hFFC0_0000;
  localparam logic [ADDR_W-1:0] MSK_12 = 32'hFFF0_0000;
  localparam logic [ADDR_W-1:0] MSK_15 = 32'hFFFE_0000;
  localparam logic [ADDR_W-1:0] MSK_16 = 32'hFFFF_0000;
  localparam logic [ADDR_W-1:0] MSK_24 = 32'hFFFF_FF00;

  localparam logic [ADDR_W-1:0] NET_LOOPBACK = 32'h7F00_0000;
  localparam logic [ADDR_W-1:0] NET_MCAST    = 32'hE000_0000;
  localparam logic [ADDR_W-1:0] NET_LINKLOC  = 32'hA9FE_0000;
  localparam logic [ADDR_W-1:0] NET_PRIV10   = 32'h0A00_0000;
  localparam logic [ADDR_W-1:0] NET_PRIV172  = 32'hAC10_0000;
  localparam logic [ADDR_W-1:0] NET_PRIV192  = 32'hC0A8_0000;
  localparam logic [ADDR_W-1:0] NET_CGNAT    = 32'h6440_0000;
  localparam logic [ADDR_W-1:0] NET_DOC1     = 32'hC000_0200;
  localparam logic [ADDR_W-1:0] NET_DOC2     = 32'hC633_6400;
  localparam logic [ADDR_W-1:0] NET_DOC3     = 32'hCB00_7100;
  localparam logic [ADDR_W-1:0] NET_BENCH    = 32'hC612_0000;
  localparam logic [ADDR_W-1:0] NET_RSVD     = 32'hF000_0000;

  // mask properties; index BYTES-1 is the top octet
  typedef struct packed {
    logic                   contig;
    logic                   proper;
    logic [BYTES-1:0]       full;
    logic [BYTES-1:0][3:0]  cnt;
  } mask_stat_t;

endpackage

### sv/ipv4c_mask_stat.sv
module ipv4c_mask_stat (
  input  logic [31:0]             mask,
  output ipv4c_pkg::mask_stat_t   stat
);
  import ipv4c_pkg::*;

  function automatic logic [3:0] lead8(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      n   = n + {3'b000, run};
    end
    return n;
  endfunction

  logic [ADDR_W-1:0] dec;
  logic              is_zero;

  always_comb begin
    dec         = mask - ADDR_W'(1);
    is_zero     = (mask == '0);
    stat.contig = is_zero || ((mask | dec) == ALL_ONES);
    stat.proper = stat.contig && !is_zero && (mask != ALL_ONES);
    for (int k = 0; k < BYTES; k++) begin
      stat.cnt[k]  = lead8(mask[k*8 +: 8]);
      stat.full[k] = (mask[k*8 +: 8] == 8'hFF);
    end
  end

endmodule

### sv/ipv4_address_and_subnet_classifier.sv
// Classifies one IPv4 address per beat against the fixed special-use ranges
// and checks it, with a reference address, against the subnet mask written on
// the cfg channel. A new beat is accepted every cycle while the pipe is not
// stalled by m_tready; the three register stages are range match and mask
// analysis, 32-bit compares and prefix sum, and final gating. Backpressure on
// m_tready stalls the pipe without loss. The mask may only be rewritten while
// no beat is in flight.
module ipv4_address_and_subnet_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,   // subnet_mask
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // addr[31:0], ref_addr[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // class_flags[9:0], reserved_special[10],
                                  // unicast_global[11], mask_contiguous[12],
                                  // prefix_len[18:13], is_network_addr[19],
                                  // is_subnet_bcast[20], is_directed_bcast[21],
                                  // same_subnet[22], zero[23]
);
  import ipv4c_pkg::*;

  logic [ADDR_W-1:0] mask;
  mask_stat_t        mstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_valid) begin
      mask <= cfg_data;
    end
  end

  ipv4c_mask_stat u_mask_stat (
    .mask (mask),
    .stat (mstat)
  );

  // pipeline advance
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  // stage 1: range match, mask properties
  logic [ADDR_W-1:0]  in_a, in_r;
  logic [FLAGS_W-1:0] flg;
  logic [ADDR_W-1:0]  a1, r1;
  logic [FLAGS_W-1:0] flg1;
  mask_stat_t         ms1;

  assign in_a = s_tdata[31:0];
  assign in_r = s_tdata[63:32];

  always_comb begin
    flg               = '0;
    flg[FLG_UNSPEC]   = (in_a == '0);
    flg[FLG_LOOPBACK] = ((in_a & MSK_8) == NET_LOOPBACK);
    flg[FLG_MCAST]    = ((in_a & MSK_4) == NET_MCAST);
    flg[FLG_LINKLOC]  = ((in_a & MSK_16) == NET_LINKLOC);
    flg[FLG_PRIVATE]  = ((in_a & MSK_8) == NET_PRIV10) ||
                        ((in_a & MSK_12) == NET_PRIV172) ||
                        ((in_a & MSK_16) == NET_PRIV192);
    flg[FLG_CGNAT]    = ((in_a & MSK_10) == NET_CGNAT);
    flg[FLG_DOC]      = ((in_a & MSK_24) == NET_DOC1) ||
                        ((in_a & MSK_24) == NET_DOC2) ||
                        ((in_a & MSK_24) == NET_DOC3);
    flg[FLG_BENCH]    = ((in_a & MSK_15) == NET_BENCH);
    flg[FLG_RSVD]     = ((in_a & MSK_4) == NET_RSVD);
    flg[FLG_LBCAST]   = (in_a == ALL_ONES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      a1   <= in_a;
      r1   <= in_r;
      flg1 <= flg;
      ms1  <= mstat;
    end
  end

  // stage 2: subnet compares, prefix length, summaries
  logic [ADDR_W-1:0]  hm, a_net;
  logic [PLEN_W-1:0]  plen;
  logic [FLAGS_W-1:0] flg2;
  logic               rsv2, ug2, contig2, proper2;
  logic [PLEN_W-1:0]  plen2;
  logic               host0_2, host1_2, dir2, same2;

  assign hm    = ~mask;
  assign a_net = a1 & mask;

  always_comb begin
    if (!ms1.full[3]) begin
      plen = PLEN_W'(ms1.cnt[3]);
    end else if (!ms1.full[2]) begin
      plen = PLEN_W'(8) + PLEN_W'(ms1.cnt[2]);
    end else if (!ms1.full[1]) begin
      plen = PLEN_W'(16) + PLEN_W'(ms1.cnt[1]);
    end else begin
      plen = PLEN_W'(24) + PLEN_W'(ms1.cnt[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      flg2    <= flg1;
      rsv2    <= flg1[FLG_UNSPEC] || flg1[FLG_LOOPBACK] || flg1[FLG_LINKLOC] ||
                 flg1[FLG_MCAST] || flg1[FLG_RSVD];
      ug2     <= (flg1[FLG_RSVD:0] == '0);
      contig2 <= ms1.contig;
      proper2 <= ms1.proper;
      plen2   <= plen;
      host0_2 <= ((a1 & hm) == '0);
      host1_2 <= ((a1 & hm) == hm);
      dir2    <= ((a_net | hm) == r1);
      same2   <= (a_net == (r1 & mask));
    end
  end

  // stage 3: gating, output register
  logic [FLAGS_W-1:0] o_flags;
  logic               o_rsv, o_ug, o_contig;
  logic [PLEN_W-1:0]  o_plen;
  logic               o_net, o_bc, o_dir, o_same;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      o_flags  <= flg2;
      o_rsv    <= rsv2;
      o_ug     <= ug2;
      o_contig <= contig2;
      o_plen   <= plen2;
      o_net    <= proper2 && host0_2;
      o_bc     <= proper2 && host1_2;
      o_dir    <= proper2 && dir2;
      o_same   <= contig2 && same2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {1'b0, o_same, o_dir, o_bc, o_net, o_plen,
                     o_contig, o_ug, o_rsv, o_flags};

  // a full, stalled pipe takes no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !m_tready) |-> !s_tready)
    else $error("beat accepted into a full stalled pipe");

  // a result appears only out of stage 2
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v2))
    else $error("output valid without a stage 2 beat");

  // subnet relations are gated by mask contiguity
  a_contig_gate: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !o_contig) |-> !(o_net || o_bc || o_dir || o_same))
    else $error("subnet relation set under non-contiguous mask");

endmodule
